[rtl/rid_pkg.sv]
`default_nettype none

package rid_pkg;

  // request payload layout
  localparam int OP_W       = 2;
  localparam int IDENT_W    = 8;
  localparam int S_TDATA_W  = 16;

  // result payload layout
  localparam int GRANT_W    = 8;
  localparam int M_TDATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_we;   // zero one map word during the clearing pass
    logic load;     // take a request, start the first word read
    logic advance;  // move the scan to the next word
    logic finish;   // update the map and cursor, load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_acquire;
    logic hit;
    logic last_step;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/rid_ctrl.sv]
`default_nettype none

module rid_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire rid_pkg::dp_status_t status,
  output rid_pkg::dp_cmd_t         cmd
);

  rid_pkg::state_t state;
  rid_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rid_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rid_pkg::ST_CLEAR: begin
        if (status.clr_last) begin
          state_next = rid_pkg::ST_IDLE;
        end
      end
      rid_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = rid_pkg::ST_EVAL;
        end
      end
      rid_pkg::ST_EVAL: begin
        if (!status.out_busy &&
            (!status.is_acquire || status.hit || status.last_step)) begin
          state_next = rid_pkg::ST_IDLE;
        end
      end
      default: state_next = rid_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      rid_pkg::ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      rid_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      rid_pkg::ST_EVAL: begin
        if (!status.out_busy) begin
          if (!status.is_acquire || status.hit || status.last_step) begin
            cmd.finish = 1'b1;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/rid_dp.sv]
`default_nettype none

module rid_dp #(
  parameter int ID_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire rid_pkg::dp_cmd_t                   cmd,
  output rid_pkg::dp_status_t                     status,
  input  wire logic [rid_pkg::S_TDATA_W-1:0]      s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [rid_pkg::M_TDATA_W-1:0]           m_tdata
);

  localparam int WORD_LOG  = (ID_BITS > 5) ? 5 : ID_BITS - 1;
  localparam int WORD_BITS = 1 << WORD_LOG;
  localparam int ADDR_BITS = ID_BITS - WORD_LOG;
  localparam int NWORDS    = 1 << ADDR_BITS;

  logic [WORD_BITS-1:0] mem [NWORDS];

  rid_pkg::op_t                  op_q;
  logic [rid_pkg::IDENT_W-1:0]   ident_q;
  logic [ADDR_BITS-1:0]          scan_addr;
  logic [ADDR_BITS:0]            step;
  logic [ID_BITS-1:0]            cursor;
  logic [ADDR_BITS-1:0]          clr_cnt;
  logic [WORD_BITS-1:0]          rdata;

  rid_pkg::op_t                  in_op;
  logic [rid_pkg::IDENT_W-1:0]   in_ident;
  logic [ID_BITS+7:0]            in_ext;
  logic [ID_BITS+7:0]            id_ext;
  logic [ID_BITS-1:0]            id_q;
  logic                          in_range;
  logic [ID_BITS-1:0]            start_id;
  logic [ADDR_BITS-1:0]          raddr;
  logic [WORD_BITS-1:0]          mask;
  logic [WORD_BITS-1:0]          free_bits;
  logic [WORD_LOG-1:0]           hit_idx;
  logic                          hit;
  logic [WORD_LOG-1:0]           bit_off;
  logic                          found;
  logic [WORD_BITS-1:0]          one_w;
  logic                          we;
  logic [ADDR_BITS-1:0]          waddr;
  logic [WORD_BITS-1:0]          wdata;
  logic [ID_BITS-1:0]            grant_id;
  logic [ID_BITS+7:0]            grant_ext;
  logic [rid_pkg::GRANT_W-1:0]   res_grant;
  logic                          res_ok;
  logic                          res_full;
  logic                          is_acq;
  logic                          last_step;

  assign in_op    = rid_pkg::op_t'(s_tdata[rid_pkg::OP_W-1:0]);
  assign in_ident = s_tdata[rid_pkg::OP_W+rid_pkg::IDENT_W-1:rid_pkg::OP_W];
  assign in_ext   = {{ID_BITS{1'b0}}, in_ident};
  assign id_ext   = {{ID_BITS{1'b0}}, ident_q};
  assign id_q     = id_ext[ID_BITS-1:0];
  assign in_range = (id_ext >> ID_BITS) == '0;
  assign start_id = cursor + {{(ID_BITS-1){1'b0}}, 1'b1};
  assign one_w    = {{(WORD_BITS-1){1'b0}}, 1'b1};
  assign is_acq   = (op_q == rid_pkg::OP_ACQUIRE);
  assign last_step = (step == (ADDR_BITS+1)'(NWORDS));

  // word address for the read issued this cycle
  always_comb begin
    priority if (cmd.load) begin
      if (in_op == rid_pkg::OP_ACQUIRE) begin
        raddr = start_id[ID_BITS-1:WORD_LOG];
      end else begin
        raddr = in_ext[ID_BITS-1:WORD_LOG];
      end
    end else if (cmd.advance) begin
      raddr = scan_addr + {{(ADDR_BITS-1){1'b0}}, 1'b1};
    end else begin
      raddr = scan_addr;
    end
  end

  // candidate mask: first word from the start offset up, wrap word below it
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      if (step == '0) begin
        mask[b] = (WORD_LOG'(b) >= start_id[WORD_LOG-1:0]);
      end else if (last_step) begin
        mask[b] = (WORD_LOG'(b) < start_id[WORD_LOG-1:0]);
      end else begin
        mask[b] = 1'b1;
      end
    end
    // the all-ones identifier is reserved
    if (scan_addr == '1) begin
      mask[WORD_BITS-1] = 1'b0;
    end
  end

  assign free_bits = ~rdata & mask;
  assign hit       = |free_bits;

  // lowest free bit
  always_comb begin
    hit_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_idx = WORD_LOG'(b);
      end
    end
  end

  assign bit_off  = id_q[WORD_LOG-1:0];
  assign found    = in_range && rdata[bit_off];
  assign grant_id = {scan_addr, hit_idx};
  assign grant_ext = {8'b0, grant_id};

  // map write
  always_comb begin
    we    = 1'b0;
    waddr = scan_addr;
    wdata = rdata;
    if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.finish) begin
      if (is_acq && hit) begin
        we    = 1'b1;
        wdata = rdata | (one_w << hit_idx);
      end else if (op_q == rid_pkg::OP_RELEASE && in_range) begin
        we    = 1'b1;
        wdata = rdata & ~(one_w << bit_off);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // result fields
  always_comb begin
    res_grant = '0;
    res_ok    = 1'b0;
    res_full  = 1'b0;
    unique case (op_q)
      rid_pkg::OP_ACQUIRE: begin
        if (hit) begin
          res_grant = grant_ext[rid_pkg::GRANT_W-1:0];
          res_ok    = 1'b1;
        end else begin
          res_full  = 1'b1;
        end
      end
      rid_pkg::OP_RELEASE, rid_pkg::OP_QUERY: begin
        res_ok = found;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  // request and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= in_op;
      ident_q <= in_ident;
      step    <= '0;
    end else if (cmd.advance) begin
      step    <= step + {{ADDR_BITS{1'b0}}, 1'b1};
    end
    if (cmd.load || cmd.advance) begin
      scan_addr <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '1;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_we) begin
        clr_cnt <= clr_cnt + {{(ADDR_BITS-1){1'b0}}, 1'b1};
      end
      if (cmd.finish && is_acq && hit) begin
        cursor <= grant_id;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {6'b0, res_full, res_ok, res_grant};
    end
  end

  always_comb begin
    status.clr_last   = (clr_cnt == '1);
    status.is_acquire = is_acq;
    status.hit        = hit;
    status.last_step  = last_step;
    status.out_busy   = m_tvalid && !m_tready;
  end

endmodule

`default_nettype wire

[rtl/rolling_id_allocator_unit.sv]
// rolling identifier allocator
// hands out unique identifiers from a space of 2^ID_BITS values; the all-ones
// value is reserved and never handed out
// request channel (s_*): tdata[1:0] op (0 acquire, 1 release, 2 query),
//   tdata[9:2] ident; a request is taken when s_tvalid and s_tready are high
// result channel (m_*): tdata[7:0] granted_ident, [8] ok, [9] full_res;
//   exactly one result per request, in request order
// the used-map sits in a memory of 2^ID_BITS/32 words of 32 bits (fewer bits
//   per word for small spaces), one word read per cycle
// release, query and unused op: the addressed map word is read, then the
//   result register loads; acquire: a word-by-word scan from the identifier
//   after the cursor, wrapping round to the bits below it, ends at the first
//   free identifier or once the whole map has been read
// a new request is taken once the previous one has finished, even while its
//   result still waits in the output register
// a stalled receiver holds the result register; a finished request then waits
//   until the register is free
// reset: clearing pass of one map word per cycle
//   with s_tready low; cursor starts at the reserved value, so the first
//   acquire grants identifier 0
`default_nettype none

module rolling_id_allocator_unit #(
  parameter int ID_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rid_pkg::S_TDATA_W-1:0] s_tdata,  // op[1:0], ident[9:2]
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rid_pkg::M_TDATA_W-1:0]      m_tdata   // granted_ident[7:0], ok[8], full_res[9]
);

  rid_pkg::dp_cmd_t    cmd;
  rid_pkg::dp_status_t status;

  // sequencing: clearing pass, request intake, word scan
  rid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // used-map memory, cursor, scan and result register
  rid_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // one request at a time: after taking a request, intake closes
  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  // no request is taken during the clearing pass
  a_no_intake_clear : assert property (@(posedge clk) disable iff (rst)
    cmd.clr_we |-> !s_tready)
    else $error("intake open during map clearing");

  // a result is never both a success and a full report
  a_ok_full_excl : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("ok and full_res both set");

  // a full report carries no identifier
  a_full_no_grant : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[9]) |-> (m_tdata[7:0] == 8'd0))
    else $error("full result with nonzero identifier");

  // the result register only loads when it is free
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result register overwritten before taken");

endmodule

`default_nettype wire
